FILE: hw/rtl/cah_pkg.sv
// Shared types and constants for the circular angle histogram.
package cah_pkg;

  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned BIDX_W   = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SHIFT_W  = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SHIFT = 2'd1;

  // commands
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [COUNT_W-1:0] BIN_COUNT_RST = 7'd64;
  localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST = 9'd0;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic                       command;
    logic [ANGLE_W-1:0]         angle_turn;
    logic signed [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    logic [BIDX_W-1:0]       bin_index;
    logic signed [SUM_W-1:0] bin_total;
    logic                    saturated;
  } res_t;

endpackage

FILE: hw/rtl/circular_angle_histogram.sv
// Circular angle histogram: angle to bin mapping and saturating bin accumulator.
//
// Each command beat (start high while busy is low) carries an angle as a
// 16-bit fraction of a full turn, a command (add or read) and a signed 32-bit
// weight. The angle maps to bin floor(angle * N / 65536 + shift / 256) wrapped
// into [0, N), where N is bin_count (0 reads as 1, values above MAX_BINS read
// as MAX_BINS) and shift is the signed 9-bit bin_shift in 1/256 bin units.
// An add saturates the bin's 48-bit signed sum and flags saturation; a read
// leaves it unchanged. Every command gives exactly one result beat, shown for
// one cycle with res_strobe_o; the receiver cannot stall it. A command can be
// accepted every cycle while busy is low; its result passes in turn through
// the input register, the index plus memory read and the accumulate plus
// result register. Back-to-back hits on the same bin are forwarded from the
// result register, so there is no hazard stall. After reset the block runs a
// clearing pass over the sum memory, one entry per cycle, with busy high;
// configuration writes are taken at all times (cfg_ready_o is always high)
// but must only change while no command is in flight.
module circular_angle_histogram #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  cah_pkg::cmd_t                  cmd_i,
  output logic                           res_strobe_o,
  output cah_pkg::res_t                  res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cah_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cah_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  // ---------------- configuration registers ----------------
  logic [cah_pkg::COUNT_W-1:0] bin_count_q;
  logic [cah_pkg::SHIFT_W-1:0] bin_shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= cah_pkg::BIN_COUNT_RST;
      bin_shift_q <= cah_pkg::BIN_SHIFT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cah_pkg::CFG_BIN_COUNT: bin_count_q <= cfg_data_i[cah_pkg::COUNT_W-1:0];
        cah_pkg::CFG_BIN_SHIFT: bin_shift_q <= cfg_data_i[cah_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Active bin count: zero reads as one, clamp at MAX_BINS.
  logic [cah_pkg::COUNT_W-1:0] nbins;
  always_comb begin
    if (bin_count_q == '0) begin
      nbins = cah_pkg::COUNT_W'(1);
    end else if (32'(bin_count_q) > MAX_BINS) begin
      nbins = cah_pkg::COUNT_W'(MAX_BINS);
    end else begin
      nbins = bin_count_q;
    end
  end

  // ---------------- clearing pass after reset ----------------
  logic             clearing_q;
  logic [IDX_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == IDX_W'(MAX_BINS - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + IDX_W'(1);
    end
  end

  assign busy = clearing_q;

  // ---------------- stage 0: input register ----------------
  logic          s0_valid_q;
  cah_pkg::cmd_t s0_q;
  logic          accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q <= cmd_i;
    end
  end

  // ---------------- stage 0 logic: angle to bin ----------------
  // Position in 1/65536 bin units, biased up by one bin so it never goes
  // negative; the top byte is floor(position) + 1, in [0, N + 1].
  logic [cah_pkg::SHIFT_W-1:0] biased_shift;
  logic [23:0]                 pos;
  logic [8:0]                  wrap_sum;
  logic [8:0]                  n_ext;
  logic [8:0]                  bin_full;
  logic [IDX_W-1:0]            s0_addr;

  always_comb begin
    biased_shift = {~bin_shift_q[cah_pkg::SHIFT_W-1], bin_shift_q[cah_pkg::SHIFT_W-2:0]};
    pos          = 24'(s0_q.angle_turn) * 24'(nbins) + {7'd0, biased_shift, 8'd0};
    n_ext        = 9'(nbins);
    wrap_sum     = {1'b0, pos[23:16]} + n_ext - 9'd1;
    // wrap_sum lies in [N - 1, 2N]
    if (wrap_sum >= {n_ext[7:0], 1'b0}) begin
      bin_full = wrap_sum - {n_ext[7:0], 1'b0};
    end else if (wrap_sum >= n_ext) begin
      bin_full = wrap_sum - n_ext;
    end else begin
      bin_full = wrap_sum;
    end
    s0_addr = IDX_W'(bin_full);
  end

  // ---------------- sum memory ----------------
  logic [cah_pkg::SUM_W-1:0] mem_q [MAX_BINS];
  logic [cah_pkg::SUM_W-1:0] rd_data_q;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [cah_pkg::SUM_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[s0_addr];
  end

  // ---------------- stage 1: accumulate ----------------
  logic                              s1_valid_q;
  logic                              s1_cmd_q;
  logic signed [cah_pkg::WEIGHT_W-1:0] s1_weight_q;
  logic [IDX_W-1:0]                  s1_addr_q;
  logic [cah_pkg::BIDX_W-1:0]        s1_bidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q    <= s0_q.command;
    s1_weight_q <= s0_q.weight;
    s1_addr_q   <= s0_addr;
    s1_bidx_q   <= bin_full[cah_pkg::BIDX_W-1:0];
  end

  // The item one ahead wrote its sum at the same edge this one read the
  // memory, so take its value from the result register on an address match.
  logic                       res_valid_q;
  cah_pkg::res_t              res_q;
  logic [IDX_W-1:0]           res_addr_q;
  logic signed [cah_pkg::SUM_W-1:0] old_sum;
  logic signed [cah_pkg::SUM_W:0]   raw_sum;
  logic signed [cah_pkg::SUM_W-1:0] new_sum;
  logic                       sat;

  always_comb begin
    if (res_valid_q && (res_addr_q == s1_addr_q)) begin
      old_sum = res_q.bin_total;
    end else begin
      old_sum = rd_data_q;
    end
    raw_sum = {old_sum[cah_pkg::SUM_W-1], old_sum}
            + (cah_pkg::SUM_W+1)'(s1_weight_q);
    sat     = 1'b0;
    new_sum = old_sum;
    if (s1_cmd_q == cah_pkg::CMD_ADD) begin
      if (raw_sum[cah_pkg::SUM_W] != raw_sum[cah_pkg::SUM_W-1]) begin
        sat     = 1'b1;
        new_sum = raw_sum[cah_pkg::SUM_W] ? cah_pkg::SUM_MIN : cah_pkg::SUM_MAX;
      end else begin
        new_sum = raw_sum[cah_pkg::SUM_W-1:0];
      end
    end
  end

  // write port: clearing pass or accumulate write-back
  always_comb begin
    if (clearing_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = s1_valid_q && (s1_cmd_q == cah_pkg::CMD_ADD);
      wr_addr = s1_addr_q;
      wr_data = new_sum;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_q.bin_index <= s1_bidx_q;
      res_q.bin_total <= new_sum;
      res_q.saturated <= sat;
      res_addr_q      <= s1_addr_q;
    end
  end

  assign res_strobe_o = res_valid_q;
  assign res_o        = res_q;

  // ---------------- assertions ----------------
  // every accepted command produces a result beat on res_strobe_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 res_strobe_o)
    else $error("result beat missing after accepted command");

  // a read never reports saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_cmd_q == cah_pkg::CMD_READ)) |=> !res_o.saturated)
    else $error("read command flagged saturation");

  // a saturated result sits on a limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.saturated) |->
      ((res_o.bin_total == cah_pkg::SUM_MAX) || (res_o.bin_total == cah_pkg::SUM_MIN)))
    else $error("saturated sum not at a limit");

  // no memory write-back while the clearing pass owns the port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_valid_q)
    else $error("command in flight during clearing pass");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the circular angle histogram: random and directed commands.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TB_MAX_BINS    = 64;
  localparam int unsigned RESULT_LATENCY = 3;
  // quiet cycles after the last result before config writes or the verdict
  localparam int unsigned DRAIN_CYCLES   = 2 * RESULT_LATENCY + 2;
  localparam int unsigned CYCLE_LIMIT    = 50_000;
  // length of each one-bin run of max-size weights
  localparam int unsigned SAT_RUN        = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // command channel
  logic start = 1'b0;
  logic busy;
  cah_pkg::cmd_t cmd_i = '0;
  logic res_strobe_o;
  cah_pkg::res_t res_o;

  // config write channel
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [cah_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [cah_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  circular_angle_histogram #(
    .MAX_BINS(TB_MAX_BINS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Histogram shadow: register copies and the bin sums, kept in 64-bit so that
  // the 48-bit saturation can be checked before clamping.
  // ---------------------------------------------------------------------------
  logic [cah_pkg::COUNT_W-1:0] shadow_count = cah_pkg::BIN_COUNT_RST;
  logic [cah_pkg::SHIFT_W-1:0] shadow_shift = cah_pkg::BIN_SHIFT_RST;
  longint                      bin_sums [TB_MAX_BINS] = '{default: 0};

  cah_pkg::cmd_t pending_commands [$];   // filled by the sequencer, drained by the driver
  cah_pkg::res_t expected_results [$];   // one entry per accepted command beat
  int unsigned   send_idle_pct = 0;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  logic          beat_taken = 1'b0;      // command beat accepted at the last rising edge
  logic          cfg_taken = 1'b0;       // config beat accepted at the last rising edge

  // zero reads as one bin, anything above the store size as the store size
  function automatic int unsigned effective_bins(logic [cah_pkg::COUNT_W-1:0] cnt);
    if (cnt == '0) return 1;
    if (cnt > TB_MAX_BINS) return TB_MAX_BINS;
    return cnt;
  endfunction

  // Position is formed in 1/65536 bin units. The shift is biased up by one
  // bin so the floor never sees a negative value; the bias comes back out in
  // the wrap.
  function automatic int unsigned angle_bin(logic [cah_pkg::ANGLE_W-1:0] angle);
    int unsigned n;
    int unsigned biased;
    int unsigned pos;
    n = effective_bins(shadow_count);
    biased = shadow_shift[cah_pkg::SHIFT_W-1] ? int'(shadow_shift) - 256
                                              : int'(shadow_shift) + 256;
    pos = int'(angle) * n + biased * 256;
    return ((pos >> 16) + n - 1) % n;
  endfunction

  // Applies one command to the shadow sums and returns the result beat it gives.
  function automatic cah_pkg::res_t accumulate_bin(cah_pkg::cmd_t c);
    cah_pkg::res_t r;
    int unsigned   idx;
    longint        total;
    idx = angle_bin(c.angle_turn);
    total = bin_sums[idx];
    r.saturated = 1'b0;
    if (c.command == cah_pkg::CMD_ADD) begin
      total = total + longint'($signed(c.weight));
      if (total > longint'(cah_pkg::SUM_MAX)) begin
        total = longint'(cah_pkg::SUM_MAX);
        r.saturated = 1'b1;
      end else if (total < longint'(cah_pkg::SUM_MIN)) begin
        total = longint'(cah_pkg::SUM_MIN);
        r.saturated = 1'b1;
      end
      bin_sums[idx] = total;
    end
    r.bin_index = cah_pkg::BIDX_W'(idx);
    r.bin_total = total[cah_pkg::SUM_W-1:0];
    return r;
  endfunction

  function automatic cah_pkg::cmd_t make_cmd(logic op, logic [cah_pkg::ANGLE_W-1:0] angle,
                                             logic [cah_pkg::WEIGHT_W-1:0] w);
    cah_pkg::cmd_t c;
    c.command = op;
    c.angle_turn = angle;
    c.weight = w;
    return c;
  endfunction

  // Mostly adds; angles spread, on bin edges, or at the ends of the turn.
  function automatic cah_pkg::cmd_t random_command(int unsigned n);
    cah_pkg::cmd_t                c;
    int unsigned                  k;
    logic [cah_pkg::ANGLE_W-1:0]  angle;
    logic [cah_pkg::WEIGHT_W-1:0] w;
    case ($urandom_range(3))
      0, 1: angle = cah_pkg::ANGLE_W'($urandom);
      2: begin
        k = $urandom_range(n - 1);
        angle = cah_pkg::ANGLE_W'((k * 65536) / n + $urandom_range(4) - 2);
      end
      default: angle = $urandom_range(1) ? '1 : cah_pkg::ANGLE_W'($urandom_range(3));
    endcase
    case ($urandom_range(3))
      0, 1: w = $urandom;
      2: w = cah_pkg::WEIGHT_W'(int'($urandom_range(200)) - 100);
      default: begin
        case ($urandom_range(3))
          0: w = 32'h7FFF_FFFF;
          1: w = 32'h8000_0000;
          2: w = '0;
          default: w = '1;
        endcase
      end
    endcase
    c = make_cmd(($urandom_range(3) == 0) ? cah_pkg::CMD_READ : cah_pkg::CMD_ADD, angle, w);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending command at the falling edge and holds it
  // until a beat is taken. Idles at random between beats.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the beat until it is taken
    end else if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      cmd_i <= pending_commands.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result beats against the oldest prediction, predicts each
  // accepted command and tracks config writes. Result check runs first so a
  // beat that arrives with a new accept compares against the older entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cah_pkg::res_t want;
    cycle_count <= cycle_count + 1;
    beat_taken <= start && !busy;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (res_strobe_o) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding: bin_index %0d bin_total %0d",
                 res_o.bin_index, res_o.bin_total);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (res_o.bin_index !== want.bin_index) begin
            $error("bin_index mismatch: expected %0d, got %0d",
                   want.bin_index, res_o.bin_index);
            fail_count++;
          end
          if (res_o.bin_total !== want.bin_total) begin
            $error("bin_total mismatch: expected %0d, got %0d",
                   want.bin_total, res_o.bin_total);
            fail_count++;
          end
          if (res_o.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0b, got %0b",
                   want.saturated, res_o.saturated);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(accumulate_bin(cmd_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cah_pkg::CFG_BIN_COUNT: shadow_count = cfg_data_i[cah_pkg::COUNT_W-1:0];
          cah_pkg::CFG_BIN_SHIFT: shadow_shift = cfg_data_i[cah_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  // Wait until every command is sent and answered, then let the pipe go quiet.
  task automatic wait_for_drain();
    do @(posedge clk_i);
    while (pending_commands.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cah_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= cah_pkg::CFG_DATA_W'(value);
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Reconfigure while idle, then queue a batch of random commands.
  task automatic run_phase(input int count, input int shift,
                           input int unsigned idle_pct, input int unsigned n_items);
    int unsigned n;
    wait_for_drain();
    write_reg(cah_pkg::CFG_BIN_COUNT, count);
    write_reg(cah_pkg::CFG_BIN_SHIFT, shift);
    send_idle_pct = idle_pct;
    n = effective_bins(cah_pkg::COUNT_W'(count));
    repeat (n_items) pending_commands.push_back(random_command(n));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at reset config (64 bins, no shift). Driver waits out
    // the clearing pass on busy.
    send_idle_pct = 0;
    pending_commands.push_back(make_cmd(cah_pkg::CMD_READ, 16'h8000, 32'h0));  // cleared bin
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h0000, 32'h7FFF_FFFF));
    // same bin back to back
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h0000, 32'h7FFF_FFFF));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_READ, 16'h0000, 32'hFFFF_FFFF));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'hFFFF, 32'h8000_0000));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'hFFFF, 32'hFFFF_FFFF));
    // last of bin 0, then first of bin 1
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h03FF, 32'h0000_0001));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h0400, 32'hFFFF_FFFF));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h0400, 32'h0000_0000));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'hAAAA, 32'h5555_5555));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h5555, 32'hAAAA_AAAA));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_READ, 16'h0400, 32'h7FFF_FFFF));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_READ, 16'hFFFF, 32'h0));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD,  16'h8000, 32'h1234_5678));

    // sender idles a quarter of the time; config extremes, sums kept across
    run_phase(64, 0, 25, 200);
    run_phase(1, 0, 25, 100);
    run_phase(0, -256, 25, 100);             // zero count reads as one bin
    run_phase(127, 255, 25, 100);            // above store size reads as 64
    run_phase(37, int'($urandom_range(511)) - 256, 25, 150);

    // sender idles about half the time
    run_phase(65, -1, 47, 150);
    run_phase(2, 128, 47, 150);
    run_phase(63, 255, 47, 150);
    run_phase(17, -256, 47, 150);

    // back to back
    run_phase(64, -256, 0, 150);
    repeat (4) run_phase($urandom_range(1, 64), int'($urandom_range(511)) - 256, 0, 100);

    // Heavy one-bin runs: max-size weights piled into one bin upward, then
    // the same downward in another bin.
    wait_for_drain();
    write_reg(cah_pkg::CFG_BIN_COUNT, 1);
    write_reg(cah_pkg::CFG_BIN_SHIFT, 0);
    repeat (SAT_RUN)
      pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD, cah_pkg::ANGLE_W'($urandom),
                                          32'h7FFF_FFFF));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_READ, 16'h1234, 32'h7FFF_FFFF));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD, 16'h4321, 32'hFFFF_FFFF));

    wait_for_drain();
    write_reg(cah_pkg::CFG_BIN_COUNT, 2);
    repeat (SAT_RUN)
      pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD, 16'h8000, 32'h8000_0000));  // bin 1
    pending_commands.push_back(make_cmd(cah_pkg::CMD_READ, 16'hC000, 32'h8000_0000));
    pending_commands.push_back(make_cmd(cah_pkg::CMD_ADD, 16'h8000, 32'h0000_0001));

    wait_for_drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cah_pkg.sv
hw/rtl/circular_angle_histogram.sv
tb/testbench.sv
